// ===== hw/rtl/swfr_pkg.sv =====
package swfr_pkg;

    // Sync word and trailer bytes
    localparam logic [7:0] SYNC_0  = 8'h58;  // 'X'
    localparam logic [7:0] SYNC_1  = 8'h42;  // 'B'
    localparam logic [7:0] SYNC_2  = 8'h55;  // 'U'
    localparam logic [7:0] SYNC_3  = 8'h53;  // 'S'
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    localparam int unsigned TDATA_W = 48;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_B      = 4'd1,
        PH_U      = 4'd2,
        PH_S      = 4'd3,
        PH_DEST   = 4'd4,
        PH_SEND   = 4'd5,
        PH_LEN_HI = 4'd6,
        PH_LEN_LO = 4'd7,
        PH_DATA   = 4'd8,
        PH_CR     = 4'd9,
        PH_LF     = 4'd10
    } t_phase;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        frame_end;
        logic        frame_ok;
        logic        for_this_device;
        logic [7:0]  sender_address;
        logic [15:0] payload_length;
        t_phase      parser_state;
    } t_result;

endpackage

// ===== hw/rtl/sync_word_frame_receiver.sv =====
// Channel   Dir  Word                        Notes
// s_axis    in   rx_byte                     one received byte per word
// m_axis    out  one result per input word   tlast = frame_end, tuser = payload_valid
// own_addr  in   own address register        write enable + data, no read-back
//
// One word per cycle sustained while m_axis_tready stays high; the path runs through
// an input register and a result register, the parse state registers feeding back on themselves.
// Synchronous active-low reset returns the parser to hunt and clears the parser and valid flags.
// m_axis_tready low holds the result; the input register still takes one word,
// after which s_axis_tready drops until the result moves on.
module sync_word_frame_receiver import swfr_pkg::*; #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_own_addr_we,
    input  logic [7:0]         i_own_addr_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [7:0] payload_byte, [15:8] payload_index, [16] frame_ok,
    // [17] for_this_device, [25:18] sender_address, [41:26] payload_length,
    // [45:42] parser_state, [47:46] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tlast,   // frame_end
    output logic               m_axis_tuser    // payload_valid
);

    logic [7:0]  r_own_addr;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;
    t_result     step_res;
    logic        out_free;
    logic        step;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= '0;
        end else if (i_own_addr_we) begin
            r_own_addr <= i_own_addr_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    swfr_parser #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_byte     (r_in_byte),
        .i_own_addr (r_own_addr),
        .o_res      (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.frame_end;
    assign m_axis_tuser  = r_out.payload_valid;
    assign m_axis_tdata  = {2'b00, r_out.parser_state, r_out.payload_length,
                            r_out.sender_address, r_out.for_this_device,
                            r_out.frame_ok, r_out.payload_index, r_out.payload_byte};

    // a checked LF always drops the parser back to hunt
    a_end_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_end |-> r_out.parser_state == PH_HUNT)
        else $error("frame end without return to hunt");

    a_payload_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.payload_valid |->
            (r_out.parser_state == PH_DATA || r_out.parser_state == PH_CR))
        else $error("payload word outside data phase");

    a_payload_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.payload_valid |->
            16'(r_out.payload_index) < r_out.payload_length)
        else $error("payload index beyond announced length");

    a_no_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.payload_valid |->
            r_out.payload_byte == 8'h00 && r_out.payload_index == 8'h00)
        else $error("payload fields set on a non-payload word");

    // the input register holds its word while the result register is full and not taken
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_in_byte))
        else $error("held input word lost");

endmodule

// ===== hw/rtl/swfr_parser.sv =====
module swfr_parser import swfr_pkg::*; #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_own_addr,
    output t_result    o_res
);

    localparam int          CNT_W   = $clog2(BUFFER_DEPTH);
    localparam logic [16:0] DEPTH_C = 17'(BUFFER_DEPTH);

    t_phase             r_phase, n_phase;
    logic               r_addressed, n_addressed;
    logic [7:0]         r_sender, n_sender;
    logic [15:0]        r_length, n_length;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_good, n_good;

    logic [CNT_W-1:0]   cnt_inc;
    logic               data_take;

    assign cnt_inc   = r_count + CNT_W'(1);
    // length of zero or beyond the window never takes a byte
    assign data_take = (16'(r_count) < r_length) && ({1'b0, r_length} < DEPTH_C);

    always_comb begin
        case (r_phase)
            PH_HUNT:   n_phase = (i_byte == SYNC_0) ? PH_B : PH_HUNT;
            PH_B:      n_phase = (i_byte == SYNC_1) ? PH_U : PH_HUNT;
            PH_U:      n_phase = (i_byte == SYNC_2) ? PH_S : PH_HUNT;
            PH_S:      n_phase = (i_byte == SYNC_3) ? PH_DEST : PH_HUNT;
            PH_DEST:   n_phase = PH_SEND;
            PH_SEND:   n_phase = PH_LEN_HI;
            PH_LEN_HI: n_phase = PH_LEN_LO;
            PH_LEN_LO: n_phase = PH_DATA;
            PH_DATA: begin
                if (data_take) begin
                    n_phase = (16'(cnt_inc) == r_length) ? PH_CR : PH_DATA;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_CR:     n_phase = (i_byte == BYTE_CR) ? PH_LF : PH_HUNT;
            PH_LF:     n_phase = PH_HUNT;
            default:   n_phase = (i_byte == SYNC_0) ? PH_B : PH_HUNT;
        endcase
    end

    always_comb begin
        n_addressed = r_addressed;
        n_sender    = r_sender;
        n_length    = r_length;
        n_count     = r_count;
        n_good      = r_good;
        o_res       = '0;
        case (r_phase)
            PH_DEST:   n_addressed = (i_byte == i_own_addr);
            PH_SEND:   n_sender    = i_byte;
            PH_LEN_HI: n_length    = {8'h00, i_byte};
            PH_LEN_LO: begin
                n_length = {r_length[7:0], i_byte};
                n_count  = '0;
            end
            PH_DATA: begin
                if (data_take) begin
                    o_res.payload_valid = 1'b1;
                    o_res.payload_byte  = i_byte;
                    o_res.payload_index = 8'(r_count);
                    n_count             = cnt_inc;
                end
            end
            PH_LF: begin
                n_good          = (i_byte == BYTE_LF);
                o_res.frame_end = 1'b1;
            end
            default: ;
        endcase
        o_res.frame_ok        = n_good;
        o_res.for_this_device = n_addressed;
        o_res.sender_address  = n_sender;
        o_res.payload_length  = n_length;
        o_res.parser_state    = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_addressed <= 1'b0;
            r_sender    <= '0;
            r_length    <= '0;
            r_count     <= '0;
            r_good      <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_addressed <= n_addressed;
            r_sender    <= n_sender;
            r_length    <= n_length;
            r_count     <= n_count;
            r_good      <= n_good;
        end
    end

endmodule
